>>> rtl/ewcv_pkg.sv
// ----------------------------------------------------------------------------
// ewcv_pkg
// Types and constants for the echo width capture and vote filter.
// ----------------------------------------------------------------------------
package ewcv_pkg;

  localparam int CH_W    = 2;
  localparam int STAMP_W = 16;
  localparam int OUT_W   = 16;
  localparam int CNT_W   = 16;

  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [CH_W-1:0]    channel;
    logic [STAMP_W-1:0] capture_value;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  result_channel;
    logic [OUT_W-1:0] pulse_width;
    logic [OUT_W-1:0] filtered_width;
    logic [CNT_W-1:0] edge_count;
    logic             expect_falling;
  } out_item_t;

endpackage

>>> rtl/echo_width_capture_vote_filter_unit.sv
// ----------------------------------------------------------------------------
// echo_width_capture_vote_filter_unit
// Multi-channel echo pulse width capture with closest-pair vote filter.
// the input beat is registered in the input reg, then the result in the result reg
// throughput: one beat per cycle while out_ready is high, limited by the single compute stage
// reset: synchronous rst_n clears all channel state and both valid flags
// ----------------------------------------------------------------------------
module echo_width_capture_vote_filter_unit #(
  parameter int NUM_CHANNELS = 3,
  parameter int TIMER_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ewcv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ewcv_pkg::out_item_t out_data
);

  ewcv_pkg::in_item_t  in_r;
  logic                in_valid_r;
  ewcv_pkg::out_item_t out_r;
  logic                out_valid_r;
  ewcv_pkg::out_item_t result;
  logic                advance;
  logic                step;

  assign advance  = !out_valid_r || out_ready;
  assign step     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  ewcv_core #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .TIMER_BITS   (TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/ewcv_vote.sv
// ----------------------------------------------------------------------------
// ewcv_vote
// Closest-pair vote over a three-sample history, keeps previous on a tie.
// ----------------------------------------------------------------------------
module ewcv_vote #(
  parameter int W = 16
) (
  input  logic [W-1:0] oldest,
  input  logic [W-1:0] middle,
  input  logic [W-1:0] newest,
  input  logic [W-1:0] prev,
  output logic [W-1:0] voted
);

  logic [W-1:0] d1;
  logic [W-1:0] d2;
  logic [W-1:0] d3;

  assign d1 = (oldest >= middle) ? (oldest - middle) : (middle - oldest);
  assign d2 = (middle >= newest) ? (middle - newest) : (newest - middle);
  assign d3 = (oldest >= newest) ? (oldest - newest) : (newest - oldest);

  always_comb begin
    priority if (d1 < d2 && d1 < d3) begin
      voted = oldest;
    end else if (d2 < d1 && d2 < d3) begin
      voted = middle;
    end else if (d3 < d1 && d3 < d2) begin
      voted = newest;
    end else begin
      voted = prev;
    end
  end

endmodule

>>> rtl/ewcv_core.sv
// ----------------------------------------------------------------------------
// ewcv_core
// Per-channel capture state, history and vote; one item per step.
// ----------------------------------------------------------------------------
module ewcv_core #(
  parameter int NUM_CHANNELS = 3,
  parameter int TIMER_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  ewcv_pkg::in_item_t  item,
  output ewcv_pkg::out_item_t result
);

  localparam int TW = TIMER_BITS;
  localparam int CW = ewcv_pkg::CNT_W;

  logic [TW-1:0] rise_r   [NUM_CHANNELS];
  logic [TW-1:0] width_r  [NUM_CHANNELS];
  logic          phase_r  [NUM_CHANNELS];
  logic [CW-1:0] cnt_r    [NUM_CHANNELS];
  logic [TW-1:0] hist1_r  [NUM_CHANNELS];
  logic [TW-1:0] hist2_r  [NUM_CHANNELS];
  logic [TW-1:0] voted_r  [NUM_CHANNELS];

  logic [NUM_CHANNELS-1:0] hit;
  logic                    in_range;
  logic [TW-1:0]           stamp;

  logic [TW-1:0] cur_rise;
  logic [TW-1:0] cur_width;
  logic          cur_phase;
  logic [CW-1:0] cur_cnt;
  logic [TW-1:0] cur_h1;
  logic [TW-1:0] cur_h2;
  logic [TW-1:0] cur_voted;

  logic [TW-1:0] rise_nxt;
  logic [TW-1:0] width_nxt;
  logic          phase_nxt;
  logic [CW-1:0] cnt_nxt;
  logic [TW-1:0] h1_nxt;
  logic [TW-1:0] h2_nxt;
  logic [TW-1:0] voted_nxt;
  logic [TW-1:0] vote_out;
  logic          is_capture;

  assign stamp      = TW'(item.capture_value);
  assign in_range   = 32'(item.channel) < NUM_CHANNELS;
  assign is_capture = (item.cmd == ewcv_pkg::CMD_CAPTURE);

  // channel select
  always_comb begin
    cur_rise  = '0;
    cur_width = '0;
    cur_phase = 1'b0;
    cur_cnt   = '0;
    cur_h1    = '0;
    cur_h2    = '0;
    cur_voted = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      hit[c] = (32'(item.channel) == c);
      if (hit[c]) begin
        cur_rise  = rise_r[c];
        cur_width = width_r[c];
        cur_phase = phase_r[c];
        cur_cnt   = cnt_r[c];
        cur_h1    = hist1_r[c];
        cur_h2    = hist2_r[c];
        cur_voted = voted_r[c];
      end
    end
  end

  ewcv_vote #(.W(TW)) u_vote (
    .oldest (cur_h1),
    .middle (cur_h2),
    .newest (cur_width),
    .prev   (cur_voted),
    .voted  (vote_out)
  );

  always_comb begin
    rise_nxt  = cur_rise;
    width_nxt = cur_width;
    phase_nxt = cur_phase;
    cnt_nxt   = cur_cnt;
    h1_nxt    = cur_h2;
    h2_nxt    = cur_width;
    voted_nxt = cur_voted;
    if (is_capture) begin
      cnt_nxt   = cur_cnt + CW'(1);
      phase_nxt = ~cur_phase;
      if (cur_phase) begin
        width_nxt = stamp - cur_rise;
      end else begin
        rise_nxt = stamp;
      end
    end else begin
      voted_nxt = vote_out;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (!rst_n) begin
        rise_r[c]  <= '0;
        width_r[c] <= '0;
        phase_r[c] <= 1'b0;
        cnt_r[c]   <= '0;
        hist1_r[c] <= '0;
        hist2_r[c] <= '0;
        voted_r[c] <= '0;
      end else if (step && hit[c]) begin
        if (is_capture) begin
          rise_r[c]  <= rise_nxt;
          width_r[c] <= width_nxt;
          phase_r[c] <= phase_nxt;
          cnt_r[c]   <= cnt_nxt;
        end else begin
          hist1_r[c] <= h1_nxt;
          hist2_r[c] <= h2_nxt;
          voted_r[c] <= voted_nxt;
        end
      end
    end
  end

  always_comb begin
    result.result_channel = item.channel;
    if (in_range) begin
      result.pulse_width    = ewcv_pkg::OUT_W'(width_nxt);
      result.filtered_width = ewcv_pkg::OUT_W'(voted_nxt);
      result.edge_count     = cnt_nxt;
      result.expect_falling = phase_nxt;
    end else begin
      result.pulse_width    = '0;
      result.filtered_width = '0;
      result.edge_count     = '0;
      result.expect_falling = 1'b0;
    end
  end

endmodule

>>> bench/tb_echo_width_capture_vote_filter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_echo_width_capture_vote_filter_unit
// Self-checking bench for the echo width capture and vote filter. Edge and
// update beats are driven with random gaps on all three channels, every accepted
// beat is mirrored in a per-channel width/vote predictor, and each result beat
// is compared field by field against the oldest predicted echo report.
// ----------------------------------------------------------------------------
module tb_echo_width_capture_vote_filter_unit;

  localparam int NCH         = 3;
  localparam int STALL_LIMIT = 5000;
  localparam int ITEM_TARGET = 950;

  class echo_scoreboard;
    logic [ewcv_pkg::STAMP_W-1:0] rise_at [NCH];
    logic [ewcv_pkg::OUT_W-1:0]   width_now [NCH];
    logic                         phase [NCH];
    logic [ewcv_pkg::CNT_W-1:0]   edges [NCH];
    logic [ewcv_pkg::OUT_W-1:0]   hist [NCH][3];
    logic [ewcv_pkg::OUT_W-1:0]   voted [NCH];
    ewcv_pkg::out_item_t          expected_echo_q[$];
    int unsigned                  mismatches;
    int unsigned                  checked;

    function new();
      for (int c = 0; c < NCH; c++) begin
        rise_at[c]   = '0;
        width_now[c] = '0;
        phase[c]     = 1'b0;
        edges[c]     = '0;
        voted[c]     = '0;
        for (int k = 0; k < 3; k++) hist[c][k] = '0;
      end
      mismatches = 0;
      checked    = 0;
    endfunction

    function logic [ewcv_pkg::OUT_W-1:0] gap(logic [ewcv_pkg::OUT_W-1:0] a,
                                             logic [ewcv_pkg::OUT_W-1:0] b);
      return (a >= b) ? a - b : b - a;
    endfunction

    function void predict_echo(ewcv_pkg::in_item_t it);
      ewcv_pkg::out_item_t        rep;
      int                         c;
      logic [ewcv_pkg::OUT_W-1:0] d_om, d_mn, d_on;
      c = int'(it.channel);
      rep = '0;
      rep.result_channel = it.channel;
      if (c < NCH) begin
        if (it.cmd == ewcv_pkg::CMD_CAPTURE) begin
          edges[c] = edges[c] + 1'b1;
          if (!phase[c]) rise_at[c] = it.capture_value;
          else width_now[c] = it.capture_value - rise_at[c];
          phase[c] = ~phase[c];
        end else begin
          hist[c][0] = hist[c][1];
          hist[c][1] = hist[c][2];
          hist[c][2] = width_now[c];
          d_om = gap(hist[c][0], hist[c][1]);
          d_mn = gap(hist[c][1], hist[c][2]);
          d_on = gap(hist[c][0], hist[c][2]);
          if (d_om < d_mn && d_om < d_on) voted[c] = hist[c][0];
          else if (d_mn < d_om && d_mn < d_on) voted[c] = hist[c][1];
          else if (d_on < d_om && d_on < d_mn) voted[c] = hist[c][2];
        end
        rep.pulse_width    = width_now[c];
        rep.filtered_width = voted[c];
        rep.edge_count     = edges[c];
        rep.expect_falling = phase[c];
      end
      expected_echo_q.push_back(rep);
    endfunction

    function void field_ok(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_echo(ewcv_pkg::out_item_t got);
      ewcv_pkg::out_item_t exp_r;
      if (expected_echo_q.size() == 0) begin
        $display("%0t unexpected result beat: expected none actual %h", $time, got);
        mismatches++;
        return;
      end
      exp_r = expected_echo_q.pop_front();
      checked++;
      field_ok("result_channel", exp_r.result_channel, got.result_channel);
      field_ok("pulse_width", exp_r.pulse_width, got.pulse_width);
      field_ok("filtered_width", exp_r.filtered_width, got.filtered_width);
      field_ok("edge_count", exp_r.edge_count, got.edge_count);
      field_ok("expect_falling", exp_r.expect_falling, got.expect_falling);
    endfunction

    function int pending();
      return expected_echo_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  ewcv_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  ewcv_pkg::out_item_t out_data;

  echo_scoreboard sb;
  int unsigned    live_items;
  int unsigned    n_capture, n_update, n_stray;
  int unsigned    cycle_no;
  int unsigned    stall_cycles;
  bit             in_calm;
  logic [ewcv_pkg::OUT_W-1:0] width_base [NCH];

  echo_width_capture_vote_filter_unit #(
    .NUM_CHANNELS(NCH),
    .TIMER_BITS  (16)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid && out_ready) sb.check_echo(out_data);
      if (in_valid && in_ready) sb.predict_echo(in_data);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    cycle_no++;
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t no beat for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side backpressure, quiet window in the middle of the run
  always @(negedge clk) begin
    if (cycle_no > 1500 && cycle_no < 2300) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) >= 7);
  end

  task automatic send_beat(logic cmd, logic [ewcv_pkg::CH_W-1:0] ch,
                           logic [ewcv_pkg::STAMP_W-1:0] val);
    ewcv_pkg::in_item_t it;
    it.cmd           = cmd;
    it.channel       = ch;
    it.capture_value = val;
    if (!in_calm) begin
      while ($urandom_range(0, 99) < 7) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (ch < NCH) begin
      live_items++;
      if (cmd == ewcv_pkg::CMD_CAPTURE) n_capture++;
      else n_update++;
    end else begin
      n_stray++;
    end
  endtask

  task automatic send_pulse(logic [ewcv_pkg::CH_W-1:0] ch,
                            logic [ewcv_pkg::STAMP_W-1:0] rise,
                            logic [ewcv_pkg::OUT_W-1:0] w);
    if (ch < NCH && sb.phase[ch]) begin
      send_beat(ewcv_pkg::CMD_CAPTURE, ch, ewcv_pkg::STAMP_W'($urandom()));
    end
    send_beat(ewcv_pkg::CMD_CAPTURE, ch, rise);
    send_beat(ewcv_pkg::CMD_CAPTURE, ch, rise + w);
    send_beat(ewcv_pkg::CMD_UPDATE, ch, ewcv_pkg::STAMP_W'($urandom()));
  endtask

  initial begin
    logic [ewcv_pkg::CH_W-1:0]  ch;
    logic [ewcv_pkg::OUT_W-1:0] w;
    int                         jit;
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    live_items   = 0;
    n_capture    = 0;
    n_update     = 0;
    n_stray      = 0;
    cycle_no     = 0;
    stall_cycles = 0;
    in_calm      = 1'b0;
    sb = new();
    for (int c = 0; c < NCH; c++) begin
      width_base[c] = ewcv_pkg::OUT_W'($urandom_range(50, 2000));
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: update before capture, stray channel, extremes, rollover, votes
    send_beat(ewcv_pkg::CMD_UPDATE, 2'd0, 16'h0000);
    send_beat(ewcv_pkg::CMD_CAPTURE, 2'd3, 16'hFFFF);
    send_beat(ewcv_pkg::CMD_UPDATE, 2'd3, 16'h0000);
    send_beat(ewcv_pkg::CMD_CAPTURE, 2'd0, 16'h0000);
    send_beat(ewcv_pkg::CMD_CAPTURE, 2'd0, 16'hFFFF);
    send_beat(ewcv_pkg::CMD_UPDATE, 2'd0, 16'hFFFF);
    send_beat(ewcv_pkg::CMD_CAPTURE, 2'd1, 16'hFFF0);
    send_beat(ewcv_pkg::CMD_CAPTURE, 2'd1, 16'h0010);
    send_beat(ewcv_pkg::CMD_UPDATE, 2'd1, 16'h5555);
    send_beat(ewcv_pkg::CMD_CAPTURE, 2'd1, 16'h1000);
    send_beat(ewcv_pkg::CMD_CAPTURE, 2'd1, 16'h1022);
    send_beat(ewcv_pkg::CMD_UPDATE, 2'd1, 16'hAAAA);
    send_beat(ewcv_pkg::CMD_UPDATE, 2'd1, 16'h0000);
    send_beat(ewcv_pkg::CMD_CAPTURE, 2'd2, 16'h8000);
    send_beat(ewcv_pkg::CMD_CAPTURE, 2'd2, 16'h8000);
    send_beat(ewcv_pkg::CMD_UPDATE, 2'd2, 16'h0000);
    send_beat(ewcv_pkg::CMD_UPDATE, 2'd2, 16'h0000);
    send_beat(ewcv_pkg::CMD_CAPTURE, 2'd2, 16'h7FFF);
    send_beat(ewcv_pkg::CMD_CAPTURE, 2'd2, 16'h8001);
    send_beat(ewcv_pkg::CMD_UPDATE, 2'd2, 16'h0000);
    send_beat(ewcv_pkg::CMD_UPDATE, 2'd0, 16'h0000);

    while (live_items < ITEM_TARGET) begin
      in_calm = (live_items > 400 && live_items < 600);
      if ($urandom_range(0, 99) < 80) begin
        ch = ($urandom_range(0, 19) == 0) ? 2'd3 :
             ewcv_pkg::CH_W'($urandom_range(0, NCH - 1));
        if (ch < NCH && $urandom_range(0, 15) == 0) begin
          width_base[ch] = ($urandom_range(0, 3) == 0) ?
                           ewcv_pkg::OUT_W'($urandom()) :
                           ewcv_pkg::OUT_W'($urandom_range(0, 2000));
        end
        jit = $urandom_range(0, 99);
        if (ch >= NCH) begin
          w = ewcv_pkg::OUT_W'($urandom());
        end else if (jit < 55) begin
          w = width_base[ch] + ewcv_pkg::OUT_W'($urandom_range(0, 6)) - 16'd3;
        end else if (jit < 75) begin
          w = width_base[ch];
        end else begin
          w = ewcv_pkg::OUT_W'($urandom());
        end
        send_pulse(ch, ewcv_pkg::STAMP_W'($urandom()), w);
      end else begin
        send_beat(1'($urandom_range(0, 1)), ewcv_pkg::CH_W'($urandom_range(0, 3)),
                  ewcv_pkg::STAMP_W'($urandom()));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d capture and %0d update beats on live channels, %0d stray",
             n_capture, n_update, n_stray);
    $display("%0d result beats compared, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
